[rtl/laq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laq_pkg
// shared widths, codes, state type and control/status bundles for the
// level-ancestor query engine
// ----------------------------------------------------------------------------
package laq_pkg;

  // default sizing
  localparam int DEF_MAX_NODES   = 1024;
  localparam int DEF_JUMP_LEVELS = 11;

  // field widths
  localparam int OP_W     = 2;
  localparam int NODE_W   = 10;
  localparam int PARENT_W = 11;
  localparam int STEPS_W  = 10;
  localparam int ANC_W    = 10;
  localparam int CNT_W    = 11;
  localparam int DEPTH_W  = 10;

  // stream word widths
  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = OP_W;
  localparam int M_TDATA_W = 16;
  localparam int M_TUSER_W = 1;

  // node count after reset
  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 11'd1024;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_Q_DEP,
    S_Q_STEP,
    S_Q_WAIT,
    S_A_RD,
    S_A_WR,
    S_B_RD1,
    S_B_P,
    S_B_RD2,
    S_B_WR,
    S_C_START,
    S_C_RD,
    S_C_CHK,
    S_C_WR,
    S_DONE
  } state_e;

  // jump table write data source
  typedef enum logic [1:0] {
    WD_LOAD,
    WD_LINK,
    WD_RAW
  } wr_sel_e;

  // kind of result word
  typedef enum logic [1:0] {
    RES_OK,
    RES_FAIL,
    RES_NODE,
    RES_U
  } res_e;

  // controller to datapath
  typedef struct packed {
    logic    cap_item;
    logic    i_clr;
    logic    i_inc;
    logic    j_inc;
    logic    j_top;
    logic    j_dec;
    logic    u_from_i;
    logic    u_from_node;
    logic    u_from_rd;
    logic    d_add;
    logic    k_sub;
    logic    tbl_rd;
    logic    tbl_rd_u;
    logic    tbl_wr;
    wr_sel_e wr_sel;
    logic    wr_up;
    logic    wr_node;
    logic    dep_rd;
    logic    dep_wr;
    logic    res_set;
    res_e    res_kind;
    logic    res_ld;
  } laq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            load_ok;
    logic            query_ok;
    logic            k_zero;
    logic            dep_lt_k;
    logic            k_ge_pow;
    logic            rd_none;
    logic            i_last;
    logic            j_zero;
    logic            j_last_b;
    logic            res_free;
  } laq_stat_t;

endpackage

[rtl/laq_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laq_dp
// datapath: item registers, jump table and depth memories, walk registers,
// node count register and the output word register
// ----------------------------------------------------------------------------
module laq_dp #(
  parameter int MAX_NODES   = laq_pkg::DEF_MAX_NODES,
  parameter int JUMP_LEVELS = laq_pkg::DEF_JUMP_LEVELS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  laq_pkg::laq_cmd_t              cmd_i,
  output laq_pkg::laq_stat_t             stat_o,
  input  logic [laq_pkg::S_TDATA_W-1:0]  s_tdata_i,
  input  logic [laq_pkg::S_TUSER_W-1:0]  s_tuser_i,
  input  logic                           cfg_valid_i,
  input  logic [laq_pkg::CNT_W-1:0]      cfg_data_i,
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic [laq_pkg::M_TDATA_W-1:0]  m_tdata_o,
  output logic [laq_pkg::M_TUSER_W-1:0]  m_tuser_o
);
  import laq_pkg::*;

  localparam int IW  = $clog2(MAX_NODES);
  localparam int LW  = $clog2(JUMP_LEVELS);
  localparam int EW  = IW + 1;
  localparam int NCW = IW + 1;
  localparam int DSW = JUMP_LEVELS;
  localparam int TBL_DEPTH = JUMP_LEVELS * (2 ** IW);
  localparam int CAP = (MAX_NODES - 1 > 1023) ? 1023 : MAX_NODES - 1;
  localparam logic [EW-1:0] NONE_ENTRY = {1'b1, {IW{1'b0}}};

  // captured item
  logic [OP_W-1:0]     op_q;
  logic [NODE_W-1:0]   node_q;
  logic [PARENT_W-1:0] parent_q;
  logic [STEPS_W-1:0]  k_q;

  // walk registers
  logic [IW-1:0]  i_q;
  logic [IW-1:0]  u_q;
  logic [LW-1:0]  j_q;
  logic [DSW-1:0] d_q;

  // configuration
  logic [CNT_W-1:0] node_count_q;
  logic [NCW-1:0]   n_act;

  // memories
  logic [EW-1:0]      tbl_mem [TBL_DEPTH];
  logic [EW-1:0]      tbl_rdata_q;
  logic [DEPTH_W-1:0] dep_mem [MAX_NODES];
  logic [DEPTH_W-1:0] dep_rdata_q;

  // result words
  logic               pend_found_q;
  logic [ANC_W-1:0]   pend_anc_q;
  logic               out_valid_q;
  logic               out_found_q;
  logic [ANC_W-1:0]   out_anc_q;

  logic [LW+IW-1:0]   rd_addr;
  logic [LW+IW-1:0]   wr_addr;
  logic [LW-1:0]      wr_layer;
  logic [IW-1:0]      wr_idx;
  logic [EW-1:0]      wr_data;
  logic [EW-1:0]      load_entry;
  logic [EW-1:0]      link_entry;
  logic [DEPTH_W-1:0] depth_capped;
  logic [31:0]        pow_j;

  // node count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
    end else if (cfg_valid_i) begin
      node_count_q <= cfg_data_i;
    end
  end

  // active node count, clamped to one..MAX_NODES
  always_comb begin
    if (node_count_q == '0) begin
      n_act = NCW'(1);
    end else if (32'(node_count_q) > MAX_NODES) begin
      n_act = NCW'(MAX_NODES);
    end else begin
      n_act = NCW'(node_count_q);
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_item) begin
      op_q     <= s_tuser_i;
      node_q   <= s_tdata_i[NODE_W-1:0];
      parent_q <= s_tdata_i[NODE_W+PARENT_W-1:NODE_W];
      k_q      <= s_tdata_i[NODE_W+PARENT_W+STEPS_W-1:NODE_W+PARENT_W];
    end else if (cmd_i.k_sub) begin
      k_q <= k_q - STEPS_W'(pow_j);
    end
  end

  assign pow_j = 32'd1 << j_q;

  // walk counters and cursors
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_item || cmd_i.i_clr) begin
      i_q <= '0;
    end else if (cmd_i.i_inc) begin
      i_q <= i_q + 1'b1;
    end

    if (cmd_i.cap_item) begin
      j_q <= '0;
    end else if (cmd_i.j_top) begin
      j_q <= LW'(JUMP_LEVELS - 1);
    end else if (cmd_i.j_inc) begin
      j_q <= j_q + 1'b1;
    end else if (cmd_i.j_dec) begin
      j_q <= j_q - 1'b1;
    end

    if (cmd_i.u_from_i) begin
      u_q <= i_q;
    end else if (cmd_i.u_from_node) begin
      u_q <= IW'(node_q);
    end else if (cmd_i.u_from_rd) begin
      u_q <= tbl_rdata_q[IW-1:0];
    end

    if (cmd_i.u_from_i) begin
      d_q <= '0;
    end else if (cmd_i.d_add) begin
      d_q <= d_q + DSW'(pow_j);
    end
  end

  // entry for a parent load: negative or too large marks the root
  always_comb begin
    if (parent_q[PARENT_W-1] || (32'(parent_q[PARENT_W-2:0]) >= MAX_NODES)) begin
      load_entry = NONE_ENTRY;
    end else begin
      load_entry = {1'b0, IW'(parent_q[PARENT_W-2:0])};
    end
  end

  // layer zero link checked against the active count
  always_comb begin
    if (tbl_rdata_q[IW] || ({1'b0, tbl_rdata_q[IW-1:0]} >= n_act)) begin
      link_entry = NONE_ENTRY;
    end else begin
      link_entry = tbl_rdata_q;
    end
  end

  // jump table read and write port select
  always_comb begin
    wr_layer = cmd_i.wr_up ? LW'(32'(j_q) + 1) : j_q;
    wr_idx   = cmd_i.wr_node ? IW'(node_q) : i_q;
    wr_addr  = {wr_layer, wr_idx};
    rd_addr  = {j_q, (cmd_i.tbl_rd_u ? u_q : i_q)};
    unique case (cmd_i.wr_sel)
      WD_LOAD: wr_data = load_entry;
      WD_LINK: wr_data = link_entry;
      default: wr_data = tbl_rdata_q;
    endcase
  end

  // jump table memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_wr) begin
      tbl_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.tbl_rd) begin
      tbl_rdata_q <= tbl_mem[rd_addr];
    end
  end

  // depth saturates at the cap
  assign depth_capped = (32'(d_q) > CAP) ? DEPTH_W'(CAP) : DEPTH_W'(d_q);

  // depth memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.dep_wr) begin
      dep_mem[i_q] <= depth_capped;
    end
    if (cmd_i.dep_rd) begin
      dep_rdata_q <= dep_mem[IW'(node_q)];
    end
  end

  // pending result
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      unique case (cmd_i.res_kind)
        RES_OK: begin
          pend_found_q <= 1'b1;
          pend_anc_q   <= '0;
        end
        RES_FAIL: begin
          pend_found_q <= 1'b0;
          pend_anc_q   <= '0;
        end
        RES_NODE: begin
          pend_found_q <= 1'b1;
          pend_anc_q   <= ANC_W'(node_q);
        end
        default: begin
          pend_found_q <= 1'b1;
          pend_anc_q   <= ANC_W'(u_q);
        end
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_ld) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ld) begin
      out_found_q <= pend_found_q;
      out_anc_q   <= pend_anc_q;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {{(M_TDATA_W - ANC_W){1'b0}}, out_anc_q};
  assign m_tuser_o  = out_found_q;

  // status towards the controller
  always_comb begin
    stat_o.op       = op_q;
    stat_o.load_ok  = 32'(node_q) < MAX_NODES;
    stat_o.query_ok = 32'(node_q) < 32'(n_act);
    stat_o.k_zero   = (k_q == '0);
    stat_o.dep_lt_k = (dep_rdata_q < k_q);
    stat_o.k_ge_pow = (32'(k_q) >= pow_j);
    stat_o.rd_none  = tbl_rdata_q[IW];
    stat_o.i_last   = ({1'b0, i_q} == NCW'(n_act - 1'b1));
    stat_o.j_zero   = (j_q == '0);
    stat_o.j_last_b = (j_q == LW'(JUMP_LEVELS - 2));
    stat_o.res_free = !out_valid_q || m_tready_i;
  end

  // a new result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_ld |-> (!out_valid_q || m_tready_i))
    else $error("result word overwritten");

  // table writes stay inside the jump layers
  a_wr_layer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tbl_wr |-> (32'(wr_layer) < JUMP_LEVELS))
    else $error("jump table write beyond top layer");

  // the layer cursor never steps below layer zero
  a_j_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.j_dec |-> (j_q != '0))
    else $error("layer cursor underflow");

  // a failed word carries a zero ancestor
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_found_q) |-> (out_anc_q == '0))
    else $error("failed result with non-zero ancestor");

endmodule

[rtl/laq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laq_ctrl
// controller: sequences loads, the three build passes and the query climb
// ----------------------------------------------------------------------------
module laq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  laq_pkg::laq_stat_t  stat_i,
  output laq_pkg::laq_cmd_t   cmd_o
);
  import laq_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign s_tready_o = (state_q == S_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        priority if (stat_i.op == OP_BUILD) begin
          state_d = S_A_RD;
        end else if (stat_i.op == OP_QUERY && stat_i.query_ok && !stat_i.k_zero) begin
          state_d = S_Q_DEP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_Q_DEP:  state_d = stat_i.dep_lt_k ? S_DONE : S_Q_STEP;
      S_Q_STEP: begin
        priority if (stat_i.k_zero) begin
          state_d = S_DONE;
        end else if (stat_i.k_ge_pow) begin
          state_d = S_Q_WAIT;
        end else begin
          state_d = S_Q_STEP;
        end
      end
      S_Q_WAIT: state_d = stat_i.rd_none ? S_DONE : S_Q_STEP;
      S_A_RD:   state_d = S_A_WR;
      S_A_WR:   state_d = stat_i.i_last ? S_B_RD1 : S_A_RD;
      S_B_RD1:  state_d = S_B_P;
      S_B_P: begin
        priority if (!stat_i.rd_none) begin
          state_d = S_B_RD2;
        end else if (stat_i.i_last && stat_i.j_last_b) begin
          state_d = S_C_START;
        end else begin
          state_d = S_B_RD1;
        end
      end
      S_B_RD2:  state_d = S_B_WR;
      S_B_WR:   state_d = (stat_i.i_last && stat_i.j_last_b) ? S_C_START : S_B_RD1;
      S_C_START: state_d = S_C_RD;
      S_C_RD:   state_d = S_C_CHK;
      S_C_CHK:  state_d = stat_i.j_zero ? S_C_WR : S_C_RD;
      S_C_WR:   state_d = stat_i.i_last ? S_DONE : S_C_START;
      S_DONE: begin
        if (stat_i.res_free) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.cap_item = accept;
    unique case (state_q)
      S_DISPATCH: begin
        priority if (stat_i.op == OP_LOAD) begin
          cmd_o.tbl_wr   = stat_i.load_ok;
          cmd_o.wr_sel   = WD_LOAD;
          cmd_o.wr_node  = 1'b1;
          cmd_o.res_set  = 1'b1;
          cmd_o.res_kind = RES_OK;
        end else if (stat_i.op == OP_BUILD) begin
          cmd_o.i_clr = 1'b1;
        end else if (stat_i.op == OP_QUERY) begin
          priority if (!stat_i.query_ok) begin
            cmd_o.res_set  = 1'b1;
            cmd_o.res_kind = RES_FAIL;
          end else if (stat_i.k_zero) begin
            cmd_o.res_set  = 1'b1;
            cmd_o.res_kind = RES_NODE;
          end else begin
            cmd_o.dep_rd      = 1'b1;
            cmd_o.u_from_node = 1'b1;
            cmd_o.j_top       = 1'b1;
          end
        end else begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_kind = RES_FAIL;
        end
      end
      S_Q_DEP: begin
        if (stat_i.dep_lt_k) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_kind = RES_FAIL;
        end
      end
      S_Q_STEP: begin
        priority if (stat_i.k_zero) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_kind = RES_U;
        end else if (stat_i.k_ge_pow) begin
          cmd_o.tbl_rd   = 1'b1;
          cmd_o.tbl_rd_u = 1'b1;
        end else begin
          cmd_o.j_dec = 1'b1;
        end
      end
      S_Q_WAIT: begin
        if (stat_i.rd_none) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_kind = RES_FAIL;
        end else begin
          cmd_o.u_from_rd = 1'b1;
          cmd_o.k_sub     = 1'b1;
        end
      end
      S_A_RD: begin
        cmd_o.tbl_rd = 1'b1;
      end
      S_A_WR: begin
        cmd_o.tbl_wr = 1'b1;
        cmd_o.wr_sel = WD_LINK;
        cmd_o.i_clr  = stat_i.i_last;
        cmd_o.i_inc  = !stat_i.i_last;
      end
      S_B_RD1: begin
        cmd_o.tbl_rd = 1'b1;
      end
      S_B_P: begin
        if (stat_i.rd_none) begin
          // no ancestor: the missing link carries up unchanged
          cmd_o.tbl_wr = 1'b1;
          cmd_o.wr_sel = WD_RAW;
          cmd_o.wr_up  = 1'b1;
          cmd_o.i_clr  = stat_i.i_last;
          cmd_o.i_inc  = !stat_i.i_last;
          cmd_o.j_inc  = stat_i.i_last && !stat_i.j_last_b;
        end else begin
          cmd_o.u_from_rd = 1'b1;
        end
      end
      S_B_RD2: begin
        cmd_o.tbl_rd   = 1'b1;
        cmd_o.tbl_rd_u = 1'b1;
      end
      S_B_WR: begin
        cmd_o.tbl_wr = 1'b1;
        cmd_o.wr_sel = WD_RAW;
        cmd_o.wr_up  = 1'b1;
        cmd_o.i_clr  = stat_i.i_last;
        cmd_o.i_inc  = !stat_i.i_last;
        cmd_o.j_inc  = stat_i.i_last && !stat_i.j_last_b;
      end
      S_C_START: begin
        cmd_o.u_from_i = 1'b1;
        cmd_o.j_top    = 1'b1;
      end
      S_C_RD: begin
        cmd_o.tbl_rd   = 1'b1;
        cmd_o.tbl_rd_u = 1'b1;
      end
      S_C_CHK: begin
        cmd_o.u_from_rd = !stat_i.rd_none;
        cmd_o.d_add     = !stat_i.rd_none;
        cmd_o.j_dec     = !stat_i.j_zero;
      end
      S_C_WR: begin
        cmd_o.dep_wr   = 1'b1;
        cmd_o.i_inc    = !stat_i.i_last;
        cmd_o.res_set  = stat_i.i_last;
        cmd_o.res_kind = RES_OK;
      end
      S_DONE: begin
        cmd_o.res_ld = stat_i.res_free;
      end
      default: begin
        cmd_o.cap_item = accept;
      end
    endcase
  end

  // one item at a time: no second word straight after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_tready_o)
    else $error("second word accepted while busy");

  // every state that consumes table data follows a table read
  a_rd_before_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_Q_WAIT || state_q == S_A_WR || state_q == S_B_P ||
     state_q == S_B_WR || state_q == S_C_CHK) |-> $past(cmd_o.tbl_rd))
    else $error("table data used without a read");

  // a finished item waits while the output word is still held
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !stat_i.res_free) |=> (state_q == S_DONE))
    else $error("left done state with output blocked");

endmodule

[rtl/level_ancestor_query.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// level_ancestor_query
// binary-lifting level-ancestor engine: parent loads, jump table and depth
// build, k-th ancestor queries
// ----------------------------------------------------------------------------
// channel   direction  handshake                     contents
// s_axis    in         s_axis_tvalid/s_axis_tready   op, node, parent, steps
// m_axis    out        m_axis_tvalid/m_axis_tready   ancestor, found
// cfg       in         cfg_valid_i/cfg_ready_o       node_count
//
// a load writes at most one table entry; a query climbs by table jumps, skipping
// layers that are too large, and ends early when the depth is short; a build sweeps
// all n active nodes, paced by the single table read port
// reset clears control and sets node_count to 1024; no clearing pass runs
// one result word is held at the output; the next item runs meanwhile and
// stalls in its final cycle until that word is taken
// ----------------------------------------------------------------------------
module level_ancestor_query #(
  parameter int MAX_NODES   = laq_pkg::DEF_MAX_NODES,
  parameter int JUMP_LEVELS = laq_pkg::DEF_JUMP_LEVELS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // node [9:0], parent [20:10], steps [30:21], zero [31]
  input  logic [laq_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // op [1:0]
  input  logic [laq_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // ancestor [9:0], zero [15:10]
  output logic [laq_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // found [0]
  output logic [laq_pkg::M_TUSER_W-1:0] m_axis_tuser,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [laq_pkg::CNT_W-1:0]     cfg_data_i
);
  import laq_pkg::*;

  laq_cmd_t  cmd;
  laq_stat_t stat;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  // controller
  laq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath
  laq_dp #(
    .MAX_NODES   (MAX_NODES),
    .JUMP_LEVELS (JUMP_LEVELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser)
  );

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the level-ancestor query engine: parent loads,
// table builds and k-th ancestor queries go in as stream words, every result
// word is checked against a local model of the jump table and depths; node
// counts are changed between phases while the engine is idle
// ----------------------------------------------------------------------------
module tb;
  import laq_pkg::*;

  localparam int NODES      = DEF_MAX_NODES;
  localparam int LEVELS     = DEF_JUMP_LEVELS;
  localparam int DEPTH_CAP  = (NODES - 1 > 1023) ? 1023 : NODES - 1;
  localparam int DRAIN_WAIT = 150000;

  // op value the engine answers with a failed result only
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
  localparam logic signed [PARENT_W-1:0] NO_LINK = -1;
  // raw parent field with the sign bit set
  localparam logic [PARENT_W-1:0] ROOT_RAW = 11'h7FF;

  typedef enum logic [1:0] {
    SHAPE_CHAIN,
    SHAPE_TREE,
    SHAPE_WILD
  } shape_e;

  typedef struct packed {
    logic [ANC_W-1:0] ancestor;
    logic             found;
  } ancestor_res_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // node [9:0], parent [20:10], steps [30:21], zero [31]
  logic [S_TDATA_W-1:0]  s_axis_tdata;
  // op [1:0]
  logic [S_TUSER_W-1:0]  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // ancestor [9:0], zero [15:10]
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  // found [0]
  logic [M_TUSER_W-1:0]  m_axis_tuser;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CNT_W-1:0]      cfg_data_i;

  // model state
  logic signed [PARENT_W-1:0] lift_tbl [NODES][LEVELS];
  logic [DEPTH_W-1:0]         depth_tbl [NODES];
  logic [CNT_W-1:0]           count_reg;
  int                         built_span;

  ancestor_res_t ancestor_q[$];
  int            mismatch_cnt;
  int            words_sent;
  bit            gaps_on;
  int            sink_hold;

  level_ancestor_query dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // node count as the engine sees it
  function automatic int active_count();
    if (count_reg == '0) return 1;
    if (count_reg > NODES) return NODES;
    return int'(count_reg);
  endfunction

  // check layer zero against the count, fill the upper layers from the layer below, then descend for depths
  function automatic void lift_rebuild();
    int n, p, u, d;
    n = active_count();
    for (int i = 0; i < n; i++) begin
      p = lift_tbl[i][0];
      if (p < 0 || p >= n) lift_tbl[i][0] = NO_LINK;
    end
    for (int j = 1; j < LEVELS; j++) begin
      for (int i = 0; i < n; i++) begin
        p = lift_tbl[i][j-1];
        lift_tbl[i][j] = (p < 0) ? NO_LINK : lift_tbl[p][j-1];
      end
    end
    for (int i = 0; i < n; i++) begin
      u = i;
      d = 0;
      for (int j = LEVELS - 1; j >= 0; j--) begin
        if (lift_tbl[u][j] >= 0) begin
          u = lift_tbl[u][j];
          d += 1 << j;
        end
      end
      depth_tbl[i] = DEPTH_W'((d > DEPTH_CAP) ? DEPTH_CAP : d);
    end
    if (n > built_span) built_span = n;
  endfunction

  // k-th ancestor by binary lifting
  function automatic ancestor_res_t ancestor_lookup(logic [NODE_W-1:0] node,
                                                    logic [STEPS_W-1:0] steps);
    ancestor_res_t r;
    int u, k, nx;
    r.ancestor = '0;
    r.found    = 1'b0;
    k = int'(steps);
    u = int'(node);
    if (u >= active_count()) return r;
    if (k == 0) begin
      r.ancestor = node;
      r.found    = 1'b1;
      return r;
    end
    if (int'(depth_tbl[node]) < k) return r;
    for (int j = LEVELS - 1; j >= 0; j--) begin
      while (k >= (1 << j)) begin
        nx = lift_tbl[u][j];
        if (nx < 0) return r;
        u = nx;
        k -= 1 << j;
      end
    end
    r.ancestor = ANC_W'(u);
    r.found    = 1'b1;
    return r;
  endfunction

  // one accepted word: update the model and return the result it causes
  function automatic ancestor_res_t apply_item(logic [OP_W-1:0] op,
                                               logic [NODE_W-1:0] node,
                                               logic [PARENT_W-1:0] parent_raw,
                                               logic [STEPS_W-1:0] steps);
    ancestor_res_t r;
    r.ancestor = '0;
    r.found    = 1'b0;
    case (op)
      OP_LOAD: begin
        lift_tbl[node][0] = parent_raw[PARENT_W-1] ? NO_LINK : $signed(parent_raw);
        r.found = 1'b1;
      end
      OP_BUILD: begin
        lift_rebuild();
        r.found = 1'b1;
      end
      OP_QUERY: begin
        r = ancestor_lookup(node, steps);
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // parent link for node i in the given tree shape
  function automatic logic [PARENT_W-1:0] pick_parent(int i, shape_e shape);
    logic [PARENT_W-1:0] neg;
    neg = PARENT_W'($urandom) | ROOT_RAW & 11'h400;
    if (shape == SHAPE_WILD) begin
      // self links, cycles, links past the node count and roots
      if ($urandom_range(0, 3) == 0) return PARENT_W'($urandom);
      return PARENT_W'($urandom_range(0, active_count()));
    end
    if (i == 0 || (shape == SHAPE_TREE && $urandom_range(0, 7) == 0)) return neg;
    if (shape == SHAPE_CHAIN && $urandom_range(0, 7) != 0) return PARENT_W'(i - 1);
    return PARENT_W'($urandom_range(0, i - 1));
  endfunction

  task automatic report_mismatch(string what);
    mismatch_cnt++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // offer one word, wait for the handshake, then predict its result
  task automatic send_word(logic [OP_W-1:0] op, logic [NODE_W-1:0] node,
                           logic [PARENT_W-1:0] parent_raw,
                           logic [STEPS_W-1:0] steps);
    int gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 15)) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, steps, parent_raw, node};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    ancestor_q.push_back(apply_item(op, node, parent_raw, steps));
    words_sent++;
  endtask

  // query with a step count around the node's depth or anywhere
  task automatic send_random_query();
    int n, node, k;
    n = active_count();
    node = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, NODES - 1))
                                       : int'($urandom_range(0, n - 1));
    if (node < built_span && $urandom_range(0, 1) == 1) begin
      k = int'(depth_tbl[node]) + 1 - int'($urandom_range(0, depth_tbl[node] + 1));
      if (k > 1023) k = 1023;
    end else begin
      k = int'($urandom_range(0, (1 << STEPS_W) - 1));
    end
    // a node no build has covered yet has no depth to read
    if (node < n && node >= built_span) k = 0;
    send_word(OP_QUERY, NODE_W'(node), PARENT_W'($urandom), STEPS_W'(k));
  endtask

  task automatic send_build();
    send_word(OP_BUILD, NODE_W'($urandom), PARENT_W'($urandom), STEPS_W'($urandom));
  endtask

  // load a parent for every node in use
  task automatic load_tree(shape_e shape);
    int n;
    n = active_count();
    for (int i = 0; i < n; i++)
      send_word(OP_LOAD, NODE_W'(i), pick_parent(i, shape), STEPS_W'($urandom));
  endtask

  // stop offering and wait until every result word is back
  task automatic wait_idle();
    int waited;
    waited = 0;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (ancestor_q.size() != 0 && waited < DRAIN_WAIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (ancestor_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", ancestor_q.size()));
      ancestor_q.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_node_count(logic [CNT_W-1:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    count_reg = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // small hand-made tree: roots of both kinds, a parent past the count, chain
  task automatic test_directed();
    gaps_on = 1'b1;
    write_node_count(11'd8);
    send_word(OP_IGNORED, '1, '1, '1);
    send_word(OP_QUERY, 10'd5, '0, 10'd0);
    send_word(OP_QUERY, 10'd1023, '0, 10'd1023);
    send_word(OP_LOAD, 10'd0, ROOT_RAW, '0);
    send_word(OP_LOAD, 10'd1, 11'd0, '0);
    send_word(OP_LOAD, 10'd2, 11'd1, '1);
    send_word(OP_LOAD, 10'd3, 11'd2, '0);
    send_word(OP_LOAD, 10'd4, 11'h400, '0);
    send_word(OP_LOAD, 10'd5, 11'd1023, '0);
    send_word(OP_LOAD, 10'd6, 11'd3, '0);
    send_word(OP_LOAD, 10'd7, 11'd6, '0);
    send_word(OP_LOAD, 10'd1023, 11'd0, '0);
    send_build();
    send_word(OP_QUERY, 10'd7, '1, 10'd5);
    send_word(OP_QUERY, 10'd7, '0, 10'd6);
    send_word(OP_QUERY, 10'd7, '0, 10'd0);
    send_word(OP_QUERY, 10'd6, '0, 10'd2);
    send_word(OP_QUERY, 10'd5, '0, 10'd1);
    send_word(OP_QUERY, 10'd1023, '0, 10'd0);
    send_word(OP_QUERY, 10'd3, '0, 10'd1023);
    send_word(OP_IGNORED, '0, '0, '0);
  endtask

  // node counts of zero and two, with cycles that saturate the depth
  task automatic test_count_extremes();
    write_node_count('0);
    send_word(OP_LOAD, 10'd0, 11'd0, '0);
    send_build();
    send_word(OP_QUERY, 10'd0, '0, 10'd1023);
    send_word(OP_QUERY, 10'd0, '0, 10'd1);
    send_word(OP_QUERY, 10'd1, '0, 10'd0);
    write_node_count(11'd2);
    send_word(OP_LOAD, 10'd0, 11'd1, '0);
    send_word(OP_LOAD, 10'd1, 11'd0, '0);
    send_build();
    send_word(OP_QUERY, 10'd1, '0, 10'd1023);
    send_word(OP_QUERY, 10'd0, '0, 10'd512);
    send_word(OP_QUERY, 10'd1, '0, 10'd1);
  endtask

  // full table with a deep chain, then a count above the table size
  task automatic test_full_tree();
    write_node_count(NODE_COUNT_RST);
    load_tree(SHAPE_CHAIN);
    send_build();
    repeat (20) send_random_query();
    write_node_count('1);
    send_build();
    repeat (10) send_random_query();
  endtask

  // long hold-off on the result side while queries keep coming
  task automatic test_backpressure();
    gaps_on   = 1'b0;
    sink_hold = 300;
    repeat (16) send_random_query();
    wait_idle();
  endtask

  // phases of random count, tree, then a mix of all operations
  task automatic test_random_phases(int target);
    int n, pick;
    while (words_sent < target) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      write_node_count(CNT_W'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40)));
      n = active_count();
      load_tree(shape_e'($urandom_range(0, 2)));
      send_build();
      repeat ($urandom_range(30, 80)) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          send_random_query();
        end else if (pick < 75) begin
          if ($urandom_range(0, 4) == 0)
            send_word(OP_LOAD, NODE_W'($urandom), PARENT_W'($urandom), '0);
          else
            send_word(OP_LOAD, NODE_W'($urandom_range(0, n - 1)),
                      pick_parent($urandom_range(0, n - 1),
                                  shape_e'($urandom_range(0, 2))),
                      STEPS_W'($urandom));
        end else if (pick < 85) begin
          send_build();
        end else if (pick < 92) begin
          send_word(OP_IGNORED, NODE_W'($urandom), PARENT_W'($urandom),
                    STEPS_W'($urandom));
        end else begin
          // switch between stretches with and without gaps
          gaps_on = !gaps_on;
        end
      end
    end
  endtask

  // last phase at full rate on both sides
  task automatic test_quiet_tail();
    gaps_on = 1'b0;
    write_node_count(11'd16);
    load_tree(SHAPE_TREE);
    send_build();
    repeat (16) send_random_query();
  endtask

  // result sink with random stall bursts and the requested hold-off
  initial begin : result_sink
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        stall     = sink_hold;
        sink_hold = 0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 15);
      end else begin
        stall = 0;
      end
      m_axis_tready <= (stall == 0);
      if (stall > 1) repeat (stall - 1) @(negedge clk_i);
    end
  end

  // compare each result word with the oldest prediction
  always @(posedge clk_i) begin : result_check
    ancestor_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (ancestor_q.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = ancestor_q.pop_front();
        if (m_axis_tdata[ANC_W-1:0] !== want.ancestor)
          report_mismatch($sformatf("ancestor %0d, wanted %0d",
                                    m_axis_tdata[ANC_W-1:0], want.ancestor));
        if (m_axis_tuser[0] !== want.found)
          report_mismatch($sformatf("found %b, wanted %b", m_axis_tuser[0], want.found));
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    count_reg     = NODE_COUNT_RST;
    built_span    = 0;
    mismatch_cnt  = 0;
    words_sent    = 0;
    gaps_on       = 1'b0;
    sink_hold     = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_count_extremes();
    test_full_tree();
    test_backpressure();
    test_random_phases(1110);
    test_quiet_tail();

    wait_idle();
    repeat (40) @(posedge clk_i);
    if (mismatch_cnt == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

[sim.f]
rtl/laq_pkg.sv
rtl/laq_dp.sv
rtl/laq_ctrl.sv
rtl/level_ancestor_query.sv
dv/tb.sv
